### rtl/tqsa_pkg.sv
`timescale 1ns / 1ps
// tqsa_pkg: operation and status codes for the two-queue shared array
// plus the step record passed from the pointer control to the top level
// no dependencies
package tqsa_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_A = 2'd0,
        OP_PUSH_B = 2'd1,
        OP_POP_A  = 2'd2,
        OP_POP_B  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        t_status status;
    } t_step;

endpackage

### rtl/two_queue_shared_array.sv
`timescale 1ns / 1ps
// two_queue_shared_array: two fifo queues growing toward each other in one
// shared memory of DEPTH words, with a one-entry result register
// depends on tqsa_pkg and tqsa_ctrl
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------
//  in      | i_valid | o_stall | i_operation, i_push_value
//  out     | o_valid | i_stall | o_pop_value, o_status
//
// one beat per cycle while o_stall is low; the result is registered and appears in
// the cycle after its input beat, paced by the single read/write port of the shared memory
// pointers update and the memory is read or written on the accepting edge
// o_stall follows i_stall while a result is held; a held result never changes
// synchronous active-low reset empties both queues; memory contents are kept
module two_queue_shared_array
    import tqsa_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_push_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(DEPTH);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic               r_out_valid;
    logic               r_pop_ok;
    t_status            r_status;
    t_step              step;
    logic [AW-1:0]      addr;
    logic               fire;

    assign o_stall = r_out_valid && i_stall;
    assign fire    = i_valid && !o_stall;

    tqsa_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_operation (i_operation),
        .o_step      (step),
        .o_addr      (addr)
    );

    always_ff @(posedge i_clk) begin
        if (fire && step.wr_en) begin
            r_mem[addr] <= i_push_value;
        end
        if (fire && step.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pop_ok <= step.rd_en;
            r_status <= step.status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_pop_ok ? r_rd_data : '0;
    assign o_status    = r_status;

endmodule

### rtl/tqsa_ctrl.sv
`timescale 1ns / 1ps
// tqsa_ctrl: head, tail and empty registers of both queues, full/empty
// decision and the memory address for each accepted beat
// depends on tqsa_pkg
module tqsa_ctrl
    import tqsa_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [1:0]    i_operation,
    output t_step         o_step,
    output logic [AW-1:0] o_addr
);

    localparam logic [AW-1:0] TOP    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTHW = (AW + 1)'(DEPTH);

    logic [AW-1:0] r_a_head, r_a_tail, r_b_head, r_b_tail;
    logic [AW-1:0] n_a_head, n_a_tail, n_b_head, n_b_tail;
    logic          r_a_empty, r_b_empty, n_a_empty, n_b_empty;
    logic [AW:0]   a_next;
    logic [AW:0]   b_rear;
    logic          full;
    t_op           op;

    always_comb begin
        op     = t_op'(i_operation);
        a_next = r_a_empty ? '0 : ({1'b0, r_a_tail} + (AW + 1)'(1));
        b_rear = r_b_empty ? DEPTHW : {1'b0, r_b_tail};
        full   = a_next >= b_rear;

        n_a_head  = r_a_head;
        n_a_tail  = r_a_tail;
        n_a_empty = r_a_empty;
        n_b_head  = r_b_head;
        n_b_tail  = r_b_tail;
        n_b_empty = r_b_empty;
        o_step    = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
        o_addr    = '0;

        unique case (op)
            OP_PUSH_A: begin
                if (full) begin
                    o_step.status = ST_FULL;
                end else begin
                    o_step.wr_en = 1'b1;
                    o_addr       = a_next[AW-1:0];
                    n_a_tail     = a_next[AW-1:0];
                    n_a_empty    = 1'b0;
                    if (r_a_empty) begin
                        n_a_head = '0;
                    end
                end
            end
            OP_PUSH_B: begin
                if (full) begin
                    o_step.status = ST_FULL;
                end else begin
                    o_step.wr_en = 1'b1;
                    n_b_empty    = 1'b0;
                    if (r_b_empty) begin
                        o_addr   = TOP;
                        n_b_head = TOP;
                        n_b_tail = TOP;
                    end else begin
                        o_addr   = r_b_tail - AW'(1);
                        n_b_tail = r_b_tail - AW'(1);
                    end
                end
            end
            OP_POP_A: begin
                if (r_a_empty) begin
                    o_step.status = ST_EMPTY;
                end else begin
                    o_step.rd_en = 1'b1;
                    o_addr       = r_a_head;
                    if (r_a_head == r_a_tail) begin
                        n_a_empty = 1'b1;
                        n_a_head  = '0;
                        n_a_tail  = '0;
                    end else begin
                        n_a_head = r_a_head + AW'(1);
                    end
                end
            end
            OP_POP_B: begin
                if (r_b_empty) begin
                    o_step.status = ST_EMPTY;
                end else begin
                    o_step.rd_en = 1'b1;
                    o_addr       = r_b_head;
                    if (r_b_head == r_b_tail) begin
                        n_b_empty = 1'b1;
                        n_b_head  = TOP;
                        n_b_tail  = TOP;
                    end else begin
                        n_b_head = r_b_head - AW'(1);
                    end
                end
            end
            default: begin
                o_step.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_head  <= '0;
            r_a_tail  <= '0;
            r_a_empty <= 1'b1;
            r_b_head  <= TOP;
            r_b_tail  <= TOP;
            r_b_empty <= 1'b1;
        end else if (i_fire) begin
            r_a_head  <= n_a_head;
            r_a_tail  <= n_a_tail;
            r_a_empty <= n_a_empty;
            r_b_head  <= n_b_head;
            r_b_tail  <= n_b_tail;
            r_b_empty <= n_b_empty;
        end
    end

    // queue a occupies head..tail going up
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_empty |-> r_a_head <= r_a_tail)
        else $error("queue a head beyond tail");

    // queue b occupies tail..head going down
    b_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_empty |-> r_b_tail <= r_b_head)
        else $error("queue b tail beyond head");

    // the two queues never overlap
    no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_a_empty && !r_b_empty) |-> r_a_tail < r_b_tail)
        else $error("queues overlap in the shared array");

    // an emptied queue a sits at its home pointers
    a_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_empty |-> (r_a_head == '0 && r_a_tail == '0))
        else $error("empty queue a off its home pointers");

    // one memory access per beat at most
    one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_step.wr_en && o_step.rd_en))
        else $error("read and write in the same beat");

endmodule
